// ----- src/bfws_pkg.sv -----
// ----------------------------------------------------------------------------
// bfws_pkg
// Shared types and constants of the bounded fifo with statistics counters.
// ----------------------------------------------------------------------------
package bfws_pkg;

   localparam int DEPTH       = 1024;
   localparam int PTR_W       = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int DATA_W      = 32;
   localparam int STAT_W      = 32;
   localparam int LIMIT_W     = 11;
   localparam int OCC_W       = 11;
   localparam int CMP_W       = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
   localparam int LIMIT_RESET = 1024;

   typedef enum logic {
      KIND_ADD = 1'b0,
      KIND_GET = 1'b1
   } kind_type;

   typedef struct packed {
      logic              valid;
      logic              accepted;
      logic              get_ok;
      logic [OCC_W-1:0]  occupancy;
      logic [STAT_W-1:0] add_tries;
      logic [STAT_W-1:0] get_tries;
      logic [STAT_W-1:0] adds_done;
      logic [STAT_W-1:0] gets_done;
   } rsp_status_type;

   typedef struct packed {
      logic              wr_en;
      logic [PTR_W-1:0]  wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic              rd_en;
      logic [PTR_W-1:0]  rd_addr;
   } ram_cmd_type;

endpackage

// ----- src/bounded_fifo_with_stats.sv -----
// ----------------------------------------------------------------------------
// bounded_fifo_with_stats
// Bounded fifo of signed 32-bit words in a ring buffer ram, with counters
// of add and get attempts and successes.
//
//   channel   ports                    handshake
//   request   req_kind, req_data_in    start high while busy low
//   response  rsp_*                    rsp_strobe, one cycle, no stall
//   config    csr_write_data           csr_write_enable
//
// one word is taken per cycle; its response appears in the cycle after accept,
// set by the registered read port of the ram
// busy stays low, so words may arrive back to back
// synchronous reset clears pointers, count and counters, limit goes to 1024
// ram contents are not cleared; only written entries are ever read
// ----------------------------------------------------------------------------
module bounded_fifo_with_stats (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_kind,
   input  logic signed [bfws_pkg::DATA_W-1:0]  req_data_in,
   input  logic                                csr_write_enable,
   input  logic [bfws_pkg::LIMIT_W-1:0]        csr_write_data,
   output logic                                rsp_strobe,
   output logic                                rsp_accepted,
   output logic signed [bfws_pkg::DATA_W-1:0]  rsp_data_out,
   output logic [bfws_pkg::OCC_W-1:0]          rsp_occupancy,
   output logic [bfws_pkg::STAT_W-1:0]         rsp_add_tries,
   output logic [bfws_pkg::STAT_W-1:0]         rsp_get_tries,
   output logic [bfws_pkg::STAT_W-1:0]         rsp_adds_done,
   output logic [bfws_pkg::STAT_W-1:0]         rsp_gets_done
);

   bfws_pkg::ram_cmd_type       ram_cmd;
   bfws_pkg::rsp_status_type    status;
   logic [bfws_pkg::DATA_W-1:0] rd_data;
   logic                        take;

   assign busy = 1'b0;
   assign take = start && !busy;

   bfws_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (take),
      .req_kind         (req_kind),
      .req_data_in      (req_data_in),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .ram_cmd          (ram_cmd),
      .status           (status)
   );

   bfws_ram #(
      .WIDTH  (bfws_pkg::DATA_W),
      .DEPTH  (bfws_pkg::DEPTH),
      .ADDR_W (bfws_pkg::PTR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_cmd.wr_en),
      .wr_addr (ram_cmd.wr_addr),
      .wr_data (ram_cmd.wr_data),
      .rd_en   (ram_cmd.rd_en),
      .rd_addr (ram_cmd.rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_strobe    = status.valid;
   assign rsp_accepted  = status.accepted;
   assign rsp_data_out  = status.get_ok ? rd_data : '0;
   assign rsp_occupancy = status.occupancy;
   assign rsp_add_tries = status.add_tries;
   assign rsp_get_tries = status.get_tries;
   assign rsp_adds_done = status.adds_done;
   assign rsp_gets_done = status.gets_done;

endmodule

// ----- src/bfws_ram.sv -----
// ----------------------------------------------------------------------------
// bfws_ram
// Simple dual port ram, one write port and one registered read port.
// ----------------------------------------------------------------------------
module bfws_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/bfws_ctrl.sv -----
// ----------------------------------------------------------------------------
// bfws_ctrl
// Ring pointers, fill count, limit register and statistics counters.
// Issues ram write for adds and ram read for gets.
// ----------------------------------------------------------------------------
module bfws_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          req_kind,
   input  logic [bfws_pkg::DATA_W-1:0]   req_data_in,
   input  logic                          csr_write_enable,
   input  logic [bfws_pkg::LIMIT_W-1:0]  csr_write_data,
   output bfws_pkg::ram_cmd_type         ram_cmd,
   output bfws_pkg::rsp_status_type      status
);

   logic [bfws_pkg::PTR_W-1:0]   head_ff, head_in;
   logic [bfws_pkg::PTR_W-1:0]   tail_ff, tail_in;
   logic [bfws_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [bfws_pkg::LIMIT_W-1:0] limit_ff;
   logic [bfws_pkg::STAT_W-1:0]  add_try_ff, add_try_in;
   logic [bfws_pkg::STAT_W-1:0]  get_try_ff, get_try_in;
   logic [bfws_pkg::STAT_W-1:0]  add_done_ff, add_done_in;
   logic [bfws_pkg::STAT_W-1:0]  get_done_ff, get_done_in;
   logic                         valid_ff, accepted_ff, get_ok_ff;
   logic                         accepted_in, get_ok_in;

   logic [bfws_pkg::CMP_W-1:0]   count_ext, limit_ext, eff_limit;
   logic                         do_add, do_get, is_get;

   always_comb begin
      count_ext = bfws_pkg::CMP_W'(count_ff);
      limit_ext = bfws_pkg::CMP_W'(limit_ff);
      eff_limit = (limit_ext > bfws_pkg::CMP_W'(bfws_pkg::DEPTH))
                  ? bfws_pkg::CMP_W'(bfws_pkg::DEPTH) : limit_ext;
      is_get    = (bfws_pkg::kind_type'(req_kind) == bfws_pkg::KIND_GET);
      do_add    = start && !is_get && (count_ext < eff_limit)
                  && (count_ext < bfws_pkg::CMP_W'(bfws_pkg::DEPTH));
      do_get    = start && is_get && (count_ff != '0);

      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      add_try_in  = add_try_ff;
      get_try_in  = get_try_ff;
      add_done_in = add_done_ff;
      get_done_in = get_done_ff;

      if (start && !is_get) begin
         add_try_in = add_try_ff + 1'b1;
      end
      if (start && is_get) begin
         get_try_in = get_try_ff + 1'b1;
      end
      if (do_add) begin
         tail_in     = (tail_ff == bfws_pkg::PTR_W'(bfws_pkg::DEPTH - 1))
                       ? '0 : tail_ff + 1'b1;
         count_in    = count_ff + 1'b1;
         add_done_in = add_done_ff + 1'b1;
      end
      if (do_get) begin
         head_in     = (head_ff == bfws_pkg::PTR_W'(bfws_pkg::DEPTH - 1))
                       ? '0 : head_ff + 1'b1;
         count_in    = count_ff - 1'b1;
         get_done_in = get_done_ff + 1'b1;
      end
      accepted_in = do_add || do_get;
      get_ok_in   = do_get;

      ram_cmd.wr_en   = do_add;
      ram_cmd.wr_addr = tail_ff;
      ram_cmd.wr_data = req_data_in;
      ram_cmd.rd_en   = do_get;
      ram_cmd.rd_addr = head_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
         add_try_ff  <= '0;
         get_try_ff  <= '0;
         add_done_ff <= '0;
         get_done_ff <= '0;
         valid_ff    <= 1'b0;
         accepted_ff <= 1'b0;
         get_ok_ff   <= 1'b0;
      end else begin
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
         add_try_ff  <= add_try_in;
         get_try_ff  <= get_try_in;
         add_done_ff <= add_done_in;
         get_done_ff <= get_done_in;
         valid_ff    <= start;
         accepted_ff <= accepted_in;
         get_ok_ff   <= get_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= bfws_pkg::LIMIT_W'(bfws_pkg::LIMIT_RESET);
      end else if (csr_write_enable) begin
         limit_ff <= csr_write_data;
      end
   end

   always_comb begin
      status.valid     = valid_ff;
      status.accepted  = accepted_ff;
      status.get_ok    = get_ok_ff;
      status.occupancy = bfws_pkg::OCC_W'(count_ff);
      status.add_tries = add_try_ff;
      status.get_tries = get_try_ff;
      status.adds_done = add_done_ff;
      status.gets_done = get_done_ff;
   end

endmodule
